[design/lgmf_pkg.sv]
// ============================================================================
// lgmf_pkg
// Shared constants and types for the grid local maximum finder: grid limits,
// configuration register codes, line buffer entry and the job record that
// passes from the front end to the result sequencer.
// ============================================================================
package lgmf_pkg;

    // grid limits and field widths
    localparam int MAX_COLS   = 32;
    localparam int MAX_ROWS   = 1024;
    localparam int PIXEL_BITS = 16;
    localparam int COL_BITS   = 5;
    localparam int ROW_BITS   = 10;
    localparam int NCOLS_BITS = 6;
    localparam int NROWS_BITS = 11;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS = 2'd1;
    localparam logic [NROWS_BITS-1:0]   NUM_ROWS_RESET = 11'd16;
    localparam logic [NCOLS_BITS-1:0]   NUM_COLS_RESET = 6'd16;

    // job queue between front end and result sequencer
    localparam int JOB_DEPTH    = 4;
    localparam int JOB_PTR_BITS = 2;

    // hit flags of one job, in report order
    localparam int HIT_COUNT = 3;
    localparam int HIT_ABOVE = 0;  // cell one row up, same column
    localparam int HIT_LEFT  = 1;  // cell one column left on the last row
    localparam int HIT_SELF  = 2;  // the incoming cell itself, last of the grid

    typedef logic signed [PIXEL_BITS-1:0] pixel_t;

    // one column of the line buffer: previous row and the row before it
    typedef struct packed {
        pixel_t up;
        pixel_t upup;
    } line_entry_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic [HIT_COUNT-1:0] hits;
    } job_t;

endpackage

[design/grid_local_maximum_finder_top.sv]
// ============================================================================
// grid_local_maximum_finder_top
// Streaming 4-neighbor local maximum finder over a configurable grid fed in
// row-major order; reports peak row/column row-major, last two rows interleaved.
// ============================================================================
//
//  channel   handshake               payload
//  -------   ---------------------   ----------------------------------
//  input     push / full             pixel (16b signed)
//  result    empty / pop             peak_row (10b), peak_col (5b), last_of_run
//  config    write_en                write_index (2b), write_data (11b)
//
//  One pixel is taken per cycle while the job queue is not full; the front
//  end decides up to three cells per pixel from its line buffer window in
//  that same cycle. The result sequencer sends one beat per cycle while
//  pop keeps up, so a pixel with several peaks holds it for a beat per
//  peak; a 4-entry job queue absorbs such bursts. A peak goes through the
//  job queue into the result output register, from which it is popped.
//  Reset clears counters and queues at once; there is no clearing pass.
//  A write to num_rows or num_cols restarts the grid at row 0, column 0.
//
module grid_local_maximum_finder_top
    import lgmf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  pixel_t                   pixel,
    output logic                     empty,
    input  logic                     pop,
    output logic [ROW_BITS-1:0]      peak_row,
    output logic [COL_BITS-1:0]      peak_col,
    output logic                     last_of_run,
    input  logic                     write_en,
    input  logic [CFG_IDX_BITS-1:0]  write_index,
    input  logic [CFG_DATA_BITS-1:0] write_data
);

    logic job_push;
    job_t job;
    job_t head_job;
    logic job_valid;
    logic job_pop;
    logic fifo_full;

    // pixel intake and classification
    lgmf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pixel       (pixel),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .job_full    (fifo_full),
        .job_push    (job_push),
        .job         (job)
    );

    // job queue
    lgmf_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (job_push),
        .wr_job    (job),
        .rd_en     (job_pop),
        .rd_job    (head_job),
        .job_valid (job_valid),
        .fifo_full (fifo_full)
    );

    // result beats
    lgmf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .job_valid   (job_valid),
        .job_pop     (job_pop),
        .pop         (pop),
        .empty       (empty),
        .peak_row    (peak_row),
        .peak_col    (peak_col),
        .last_of_run (last_of_run)
    );

    assign full = fifo_full;

`ifndef SYNTHESIS
    // a job never enters a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !fifo_full)
        else $error("job pushed into full queue");

    // only pixels that decided a peak make a job
    a_job_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job.hits != '0))
        else $error("job pushed without hits");

    // a run that is not finished keeps a beat on the result ports
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_of_run) |=> !empty)
        else $error("result run broken before its last beat");
`endif

endmodule

[design/lgmf_front.sv]
// ============================================================================
// lgmf_front
// Front end: configuration registers, grid position counters, line buffer
// with prefetch window, and the neighbor compares that classify each pixel
// into a job of up to three decided cells.
// ============================================================================
module lgmf_front
    import lgmf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  pixel_t                   pixel,
    input  logic                     write_en,
    input  logic [CFG_IDX_BITS-1:0]  write_index,
    input  logic [CFG_DATA_BITS-1:0] write_data,
    input  logic                     job_full,
    output logic                     job_push,
    output job_t                     job
);

    logic [NROWS_BITS-1:0] num_rows_reg;
    logic [NCOLS_BITS-1:0] num_cols_reg;
    logic [ROW_BITS-1:0]   row_count_reg;
    logic [COL_BITS-1:0]   col_count_reg;

    // line buffer, one entry per column
    line_entry_t line_mem [MAX_COLS];

    // window around the current column
    line_entry_t ahead_reg;   // column c
    line_entry_t ahead2_reg;  // column c+1, wrapping
    pixel_t      up_left_reg;
    pixel_t      prev_pixel_reg;
    pixel_t      prev_prev_reg;

    logic [NROWS_BITS-1:0] rows_eff;
    logic [NCOLS_BITS-1:0] cols_eff;
    logic [NCOLS_BITS-1:0] sum2;
    logic [NCOLS_BITS-1:0] fetch2_wide;
    logic [COL_BITS-1:0]   fetch2_col;
    logic                  accept;
    logic                  last_row;
    logic                  last_col;
    logic                  bypass2;
    line_entry_t           wr_entry;
    pixel_t                up_v;
    pixel_t                upup_v;
    pixel_t                right_v;
    pixel_t                left_v;
    pixel_t                left2_v;
    pixel_t                ul_v;
    logic [HIT_COUNT-1:0]  hits;

    assign accept = push && !job_full;

    // clamp grid size into range
    always_comb
    begin
        if (num_rows_reg == '0)
            rows_eff = NROWS_BITS'(1);
        else if (num_rows_reg > NROWS_BITS'(MAX_ROWS))
            rows_eff = NROWS_BITS'(MAX_ROWS);
        else
            rows_eff = num_rows_reg;

        if (num_cols_reg == '0)
            cols_eff = NCOLS_BITS'(1);
        else if (num_cols_reg > NCOLS_BITS'(MAX_COLS))
            cols_eff = NCOLS_BITS'(MAX_COLS);
        else
            cols_eff = num_cols_reg;
    end

    assign last_row = (NROWS_BITS'(row_count_reg) + NROWS_BITS'(1)) == rows_eff;
    assign last_col = (NCOLS_BITS'(col_count_reg) + NCOLS_BITS'(1)) == cols_eff;

    // column two ahead, modulo the row width
    assign sum2 = NCOLS_BITS'(col_count_reg) + NCOLS_BITS'(2);
    always_comb
    begin
        if (cols_eff == NCOLS_BITS'(1))
            fetch2_wide = '0;
        else if (sum2 >= cols_eff)
            fetch2_wide = sum2 - cols_eff;
        else
            fetch2_wide = sum2;
    end
    assign fetch2_col = fetch2_wide[COL_BITS-1:0];
    assign bypass2    = (fetch2_col == col_count_reg);

    assign wr_entry = '{up: pixel, upup: ahead_reg.up};

    // neighbor compares
    always_comb
    begin
        up_v    = ahead_reg.up;
        upup_v  = ahead_reg.upup;
        right_v = ahead2_reg.up;
        left_v  = prev_pixel_reg;
        left2_v = prev_prev_reg;
        ul_v    = up_left_reg;

        hits[HIT_ABOVE] = (row_count_reg != '0)
                       && ((row_count_reg < ROW_BITS'(2)) || (up_v >= upup_v))
                       && ((col_count_reg == '0) || (up_v >= ul_v))
                       && (last_col || (up_v >= right_v))
                       && (up_v >= pixel);

        hits[HIT_LEFT] = last_row && (col_count_reg != '0)
                      && ((row_count_reg == '0) || (left_v >= ul_v))
                      && ((col_count_reg < COL_BITS'(2)) || (left_v >= left2_v))
                      && (left_v >= pixel);

        hits[HIT_SELF] = last_row && last_col
                      && ((row_count_reg == '0) || (pixel >= up_v))
                      && ((col_count_reg == '0) || (pixel >= left_v));
    end

    assign job_push = accept && (hits != '0);
    assign job      = '{row: row_count_reg, col: col_count_reg, hits: hits};

    // configuration and grid position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= NUM_ROWS_RESET;
            num_cols_reg  <= NUM_COLS_RESET;
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (write_en)
        begin
            unique case (write_index)
                REG_NUM_ROWS: num_rows_reg <= write_data;
                REG_NUM_COLS: num_cols_reg <= write_data[NCOLS_BITS-1:0];
                default:      ;
            endcase
            if (write_index == REG_NUM_ROWS || write_index == REG_NUM_COLS)
            begin
                row_count_reg <= '0;
                col_count_reg <= '0;
            end
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_count_reg <= '0;
                row_count_reg <= last_row ? '0 : row_count_reg + 1'b1;
            end
            else
            begin
                col_count_reg <= col_count_reg + 1'b1;
            end
        end
    end

    // line buffer write and window prefetch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_count_reg] <= wr_entry;
            ahead2_reg  <= bypass2 ? wr_entry : line_mem[fetch2_col];
            ahead_reg   <= (cols_eff == NCOLS_BITS'(1)) ? wr_entry : ahead2_reg;
            up_left_reg <= ahead_reg.up;
            if (last_col)
            begin
                prev_pixel_reg <= '0;
                prev_prev_reg  <= '0;
            end
            else
            begin
                prev_pixel_reg <= pixel;
                prev_prev_reg  <= prev_pixel_reg;
            end
        end
    end

endmodule

[design/lgmf_job_fifo.sv]
// ============================================================================
// lgmf_job_fifo
// Short job queue between the front end and the result sequencer, so either
// side can stall without holding up the other.
// ============================================================================
module lgmf_job_fifo
    import lgmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    input  logic rd_en,
    output job_t rd_job,
    output logic job_valid,
    output logic fifo_full
);

    job_t                  slot_mem [JOB_DEPTH];
    logic [JOB_PTR_BITS-1:0] wr_ptr_reg;
    logic [JOB_PTR_BITS-1:0] rd_ptr_reg;
    logic [JOB_PTR_BITS:0]   count_reg;
    logic                    do_wr;
    logic                    do_rd;

    assign fifo_full = (count_reg == (JOB_PTR_BITS+1)'(JOB_DEPTH));
    assign job_valid = (count_reg != '0);
    assign do_wr     = wr_en && !fifo_full;
    assign do_rd     = rd_en && job_valid;
    assign rd_job    = slot_mem[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_mem[wr_ptr_reg] <= wr_job;
    end

endmodule

[design/lgmf_back.sv]
// ============================================================================
// lgmf_back
// Result sequencer: walks the hit flags of the head job in report order and
// loads one result beat per cycle into the output register while it is free.
// ============================================================================
module lgmf_back
    import lgmf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  job_t                head_job,
    input  logic                job_valid,
    output logic                job_pop,
    input  logic                pop,
    output logic                empty,
    output logic [ROW_BITS-1:0] peak_row,
    output logic [COL_BITS-1:0] peak_col,
    output logic                last_of_run
);

    logic                 out_valid_reg;
    logic [HIT_COUNT-1:0] done_reg;
    logic [ROW_BITS-1:0]  peak_row_reg;
    logic [COL_BITS-1:0]  peak_col_reg;
    logic                 last_reg;

    logic [HIT_COUNT-1:0] remaining;
    logic [HIT_COUNT-1:0] pick;
    logic                 pick_last;
    logic                 load;

    // lowest hit still to report
    assign remaining = head_job.hits & ~done_reg;
    assign pick      = remaining & (~remaining + 1'b1);
    assign pick_last = (remaining & ~pick) == '0;

    assign load    = job_valid && (!out_valid_reg || pop);
    assign job_pop = load && pick_last;

    // output beat control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            done_reg      <= pick_last ? '0 : (done_reg | pick);
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            peak_row_reg <= pick[HIT_ABOVE] ? head_job.row - 1'b1 : head_job.row;
            peak_col_reg <= pick[HIT_LEFT]  ? head_job.col - 1'b1 : head_job.col;
            last_reg     <= pick_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign peak_row    = peak_row_reg;
    assign peak_col    = peak_col_reg;
    assign last_of_run = last_reg;

endmodule
